FILE: rtl/core/mcbs_pkg.sv
// Shared types, codes and constant reply tables of the memory card block store.
`timescale 1ns / 1ps
package mcbs_pkg;

   localparam logic [2:0] FUNC_DEVINFO = 3'd0;
   localparam logic [2:0] FUNC_MEDIA   = 3'd1;
   localparam logic [2:0] FUNC_READ    = 3'd2;
   localparam logic [2:0] FUNC_WRITE   = 3'd3;
   localparam logic [2:0] FUNC_SYNC    = 3'd4;

   localparam logic CSR_WRITE_PROTECT = 1'b0;
   localparam logic CSR_FUNCTION_CODE = 1'b1;

   localparam logic [31:0] FUNCTION_CODE_RESET = 32'h0200_0000;
   localparam logic [31:0] FILE_ERROR_BASE     = 32'h0080_0000;
   localparam logic [4:0]  DEVINFO_WORDS       = 5'd28;
   localparam logic [4:0]  MEDIA_WORDS         = 5'd7;

   typedef enum logic [2:0] {
      RSP_DEVINFO = 3'd0,
      RSP_DATA    = 3'd1,
      RSP_ACK     = 3'd2,
      RSP_FILEERR = 3'd3,
      RSP_NOFUNC  = 3'd4,
      RSP_UNKNOWN = 3'd5
   } rsp_code_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_PARTITION = 3'd1,
      ERR_PHASE     = 3'd2,
      ERR_BLOCK     = 3'd3,
      ERR_WRFAIL    = 3'd4,
      ERR_LENGTH    = 3'd5
   } err_code_type;

   typedef enum logic [2:0] {
      CMD_PLAIN,
      CMD_DEVINFO,
      CMD_MEDIA,
      CMD_READ,
      CMD_COMMIT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      rsp_code_type rsp;
      err_code_type err;
      logic [31:0]  word;
      logic [31:0]  location;
   } cmd_type;

   // device info payload, word 0 is replaced by the function code
   function automatic logic [31:0] dev_word(input logic [4:0] idx);
      logic [31:0] w;
      unique case (idx)
         5'd1:  w = 32'h0041_0F00;
         5'd4:  w = 32'h6956_00FF;
         5'd5:  w = 32'h6C61_7573;
         5'd6:  w = 32'h6D65_4D20;
         5'd7:  w = 32'h2079_726F;
         5'd8, 5'd9, 5'd10, 5'd11, 5'd26: w = 32'h2020_2020;
         5'd12: w = 32'h646F_7250;
         5'd13: w = 32'h6465_6375;
         5'd14: w = 32'h2079_4220;
         5'd15: w = 32'h5520_726F;
         5'd16: w = 32'h7265_646E;
         5'd17: w = 32'h6369_4C20;
         5'd18: w = 32'h6573_6E65;
         5'd19: w = 32'h6F72_4620;
         5'd20: w = 32'h4553_206D;
         5'd21: w = 32'h4520_4147;
         5'd22: w = 32'h5245_544E;
         5'd23: w = 32'h5349_5250;
         5'd24: w = 32'h4C2C_5345;
         5'd25: w = 32'h202E_4454;
         5'd27: w = 32'h0082_007C;
         default: w = 32'h0;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] media_word(input logic [2:0] idx);
      logic [31:0] w;
      unique case (idx)
         3'd1: w = 32'h0000_00FF;
         3'd2: w = 32'h00FE_00FF;
         3'd3: w = 32'h00FD_0001;
         3'd4: w = 32'h0000_000D;
         3'd5: w = 32'h001F_00C8;
         3'd6: w = 32'h0080_0000;
         default: w = 32'h0;
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/mcbs_if.sv
// Request and response channel interfaces of the memory card block store.
`timescale 1ns / 1ps
interface mcbs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [7:0]  payload_len;
   logic [31:0] function_word;
   logic [31:0] location;
   logic [31:0] data0;
   logic [31:0] data1;
   logic [31:0] data2;
   logic [31:0] data3;
   logic        last;
   modport source (output valid, func, payload_len, function_word, location,
                   data0, data1, data2, data3, last, input ready);
   modport sink (input valid, func, payload_len, function_word, location,
                 data0, data1, data2, data3, last, output ready);
endinterface

interface mcbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  response;
   logic [2:0]  error;
   logic [31:0] word0;
   logic [31:0] word1;
   logic [31:0] word2;
   logic [31:0] word3;
   logic [2:0]  valid_words;
   logic        last_result;
   modport source (output valid, response, error, word0, word1, word2, word3,
                   valid_words, last_result, input ready);
   modport sink (input valid, response, error, word0, word1, word2, word3,
                 valid_words, last_result, output ready);
endinterface

FILE: rtl/core/mcbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mcbs_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/mcbs_front.sv
// Front end: request tracking, phase buffer fill, checks and pending write state.
`timescale 1ns / 1ps
module mcbs_front #(
   parameter int BLOCK_COUNT = 256,
   parameter int BLOCK_BYTES = 512,
   parameter int PHASE_BYTES = 128,
   localparam int ROWS = BLOCK_BYTES / 16,
   localparam int PB_AW = $clog2(ROWS)
) (
   input  logic                  clock,
   input  logic                  reset,
   mcbs_req_if.sink              req,
   input  logic                  write_protect,
   input  logic [31:0]           function_code,
   input  logic                  wp_set,
   input  logic                  commit_done,
   output logic                  pb_wr_en,
   output logic [PB_AW-1:0]      pb_wr_addr,
   output logic [127:0]          pb_wr_data,
   output logic                  q_push,
   output mcbs_pkg::cmd_type     q_cmd,
   input  logic                  q_full
);
   import mcbs_pkg::*;

   localparam int PHASE_WORDS = PHASE_BYTES / 4;
   localparam int PHASE_ITEMS = PHASE_BYTES / 16;
   localparam int PHASE_COUNT = BLOCK_BYTES / PHASE_BYTES;
   localparam int CNT_W = $clog2(PHASE_ITEMS + 2);
   localparam int BLK_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int NP_W = $clog2(PHASE_COUNT + 1);

   logic             in_req_ff, in_req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0]       h_func_ff;
   logic [7:0]       h_len_ff;
   logic [31:0]      h_fword_ff, h_loc_ff;
   logic             pend_valid_ff, pend_valid_in;
   logic [BLK_W-1:0] pend_block_ff, pend_block_in;
   logic [NP_W-1:0]  pend_next_ff, pend_next_in;
   logic             busy_ff, busy_in;

   logic             accept, fin;
   logic [2:0]       hf;
   logic [7:0]       hl;
   logic [31:0]      hw, hloc;
   logic [15:0]      blk;
   logic [7:0]       part;
   logic [8:0]       ph9;
   logic [CNT_W-1:0] cnt_now, cnt_next;
   logic             fmatch, blk_in, ph_in, blk_same;
   logic             drop, start, adv;
   err_code_type     fe;
   cmd_type          cmd;

   assign req.ready = !busy_ff && !q_full;
   assign accept = req.valid && req.ready;
   assign fin = accept && req.last;

   assign hf   = in_req_ff ? h_func_ff  : req.func;
   assign hl   = in_req_ff ? h_len_ff   : req.payload_len;
   assign hw   = in_req_ff ? h_fword_ff : req.function_word;
   assign hloc = in_req_ff ? h_loc_ff   : req.location;
   assign blk  = hloc[15:0];
   assign part = hloc[31:24];
   assign ph9  = {1'b0, hloc[23:16]};

   assign cnt_now  = in_req_ff ? count_ff : '0;
   assign cnt_next = (cnt_now == CNT_W'(PHASE_ITEMS + 1)) ? cnt_now : cnt_now + 1'b1;

   assign fmatch   = (hl != 8'd0) && (hw == function_code);
   assign blk_in   = 17'(blk) < 17'(BLOCK_COUNT);
   assign ph_in    = ph9 < 9'(PHASE_COUNT);
   assign blk_same = 16'(pend_block_ff) == blk;

   // write data lands in the phase buffer as it arrives
   assign pb_wr_en   = accept && (hf == FUNC_WRITE) && fmatch &&
                       (cnt_now < CNT_W'(PHASE_ITEMS)) && ph_in;
   assign pb_wr_addr = PB_AW'(32'(ph9) * PHASE_ITEMS + 32'(cnt_now));
   assign pb_wr_data = {req.data3, req.data2, req.data1, req.data0};

   always_comb begin
      cmd = '{kind: CMD_PLAIN, rsp: RSP_ACK, err: ERR_NONE, word: 32'h0, location: hloc};
      fe = ERR_NONE;
      drop = 1'b0;
      start = 1'b0;
      adv = 1'b0;
      priority if (hf == FUNC_DEVINFO) begin
         cmd.kind = CMD_DEVINFO;
         cmd.rsp = RSP_DEVINFO;
      end else if (hf > FUNC_SYNC) begin
         cmd.rsp = RSP_UNKNOWN;
      end else if (!fmatch) begin
         cmd.rsp = RSP_NOFUNC;
      end else if (hf == FUNC_MEDIA || hf == FUNC_READ) begin
         priority if (hl != 8'd2) fe = ERR_LENGTH;
         else if (part != 8'd0) fe = ERR_PARTITION;
         else if (ph9 != 9'd0) fe = ERR_PHASE;
         else if (hf == FUNC_MEDIA) begin
            if (blk != 16'd0) fe = ERR_BLOCK;
            else begin
               cmd.kind = CMD_MEDIA;
               cmd.rsp = RSP_DATA;
            end
         end else if (!blk_in) fe = ERR_BLOCK;
         else begin
            cmd.kind = CMD_READ;
            cmd.rsp = RSP_DATA;
         end
      end else if (hf == FUNC_WRITE) begin
         drop = 1'b1;
         priority if (hl != 8'(2 + PHASE_WORDS) || cnt_next != CNT_W'(PHASE_ITEMS))
            fe = ERR_LENGTH;
         else if (part != 8'd0) fe = ERR_PARTITION;
         else if (!blk_in) fe = ERR_BLOCK;
         else if (!ph_in) fe = ERR_PHASE;
         else if (write_protect) fe = ERR_WRFAIL;
         else if (ph9 == 9'd0) begin
            drop = 1'b0;
            start = 1'b1;
            adv = 1'b1;
         end else if (!pend_valid_ff || !blk_same || 9'(pend_next_ff) != ph9) begin
            fe = (pend_valid_ff && !blk_same) ? ERR_BLOCK : ERR_PHASE;
         end else begin
            drop = 1'b0;
            adv = 1'b1;
         end
      end else begin
         // sync
         drop = 1'b1;
         priority if (hl != 8'd2) fe = ERR_LENGTH;
         else if (part != 8'd0) fe = ERR_PARTITION;
         else if (!blk_in) fe = ERR_BLOCK;
         else if (ph9 != 9'(PHASE_COUNT)) fe = ERR_PHASE;
         else if (!pend_valid_ff) begin
            fe = ERR_PHASE;
            drop = 1'b0;
         end else if (!blk_same) fe = ERR_BLOCK;
         else if (pend_next_ff != NP_W'(PHASE_COUNT)) fe = ERR_PHASE;
         else if (write_protect) fe = ERR_WRFAIL;
         else begin
            cmd.kind = CMD_COMMIT;
            cmd.location = 32'(pend_block_ff);
         end
      end
      if (fe != ERR_NONE) begin
         cmd.kind = CMD_PLAIN;
         cmd.rsp = RSP_FILEERR;
         cmd.err = fe;
         cmd.word = FILE_ERROR_BASE << fe;
      end
   end

   assign q_push = fin;
   assign q_cmd = cmd;

   always_comb begin
      in_req_in = in_req_ff;
      count_in = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_block_in = pend_block_ff;
      pend_next_in = pend_next_ff;
      busy_in = busy_ff;
      if (accept) begin
         in_req_in = !req.last;
         count_in = req.last ? '0 : cnt_next;
      end
      if (fin) begin
         if (drop) pend_valid_in = 1'b0;
         if (start) begin
            pend_valid_in = 1'b1;
            pend_block_in = blk[BLK_W-1:0];
         end
         if (adv) pend_next_in = NP_W'(ph9 + 9'd1);
         if (cmd.kind == CMD_COMMIT) busy_in = 1'b1;
      end
      if (commit_done) busy_in = 1'b0;
      if (wp_set) pend_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_req_ff <= 1'b0;
         count_ff <= '0;
         pend_valid_ff <= 1'b0;
         pend_block_ff <= '0;
         pend_next_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         in_req_ff <= in_req_in;
         count_ff <= count_in;
         pend_valid_ff <= pend_valid_in;
         pend_block_ff <= pend_block_in;
         pend_next_ff <= pend_next_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !in_req_ff) begin
         h_func_ff <= req.func;
         h_len_ff <= req.payload_len;
         h_fword_ff <= req.function_word;
         h_loc_ff <= req.location;
      end
   end

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !accept) else $error("beat taken during commit");
   a_commit_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (fin && cmd.kind == CMD_COMMIT) |=> busy_ff) else $error("commit not flagged");
   a_no_fill_over_count: assert property (@(posedge clock) disable iff (reset)
      pb_wr_en |-> (cnt_now < CNT_W'(PHASE_ITEMS))) else $error("phase buffer overrun");
endmodule

FILE: rtl/core/mcbs_cmd_queue.sv
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps
module mcbs_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mcbs_pkg::cmd_type push_cmd,
   input  logic              pop,
   output mcbs_pkg::cmd_type pop_cmd,
   output logic              full,
   output logic              empty
);
   import mcbs_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   assign full = fill_ff == 2'd2;
   assign empty = fill_ff == 2'd0;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue underflow");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3) else $error("queue fill count out of range");
endmodule

FILE: rtl/core/mcbs_back.sv
// Back end: block storage, commit copy and result streaming.
`timescale 1ns / 1ps
module mcbs_back #(
   parameter int BLOCK_COUNT = 256,
   parameter int BLOCK_BYTES = 512,
   localparam int ROWS = BLOCK_BYTES / 16,
   localparam int PB_AW = $clog2(ROWS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       function_code,
   input  logic              q_empty,
   input  mcbs_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              pb_rd_en,
   output logic [PB_AW-1:0]  pb_rd_addr,
   input  logic [127:0]      pb_rd_data,
   output logic              commit_done,
   mcbs_rsp_if.source        rsp
);
   import mcbs_pkg::*;

   localparam int BLK_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
   localparam int ST_DEPTH = BLOCK_COUNT * ROWS;
   localparam int SA_W = $clog2(ST_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_PLAIN, S_TABLE, S_RD_ISSUE, S_RD_LOAD, S_RD_TAIL, S_CP_READ, S_CP_WRITE
   } state_type;

   state_type        state_ff;
   cmd_type          cmd_ff;
   logic [SA_W-1:0]  base_ff;
   logic [PB_AW-1:0] row_ff;
   logic [2:0]       k_ff;
   logic [95:0]      prev_hi_ff;
   logic             blk_written_ff;
   logic             written_ff [BLOCK_COUNT];
   logic             commit_done_ff;

   logic             rsp_valid_ff;
   rsp_code_type     rsp_code_ff;
   err_code_type     rsp_err_ff;
   logic [31:0]      w0_ff, w1_ff, w2_ff, w3_ff;
   logic [2:0]       vw_ff;
   logic             last_ff;

   logic             slot_free;
   logic [BLK_W-1:0] q_blk, c_blk;
   logic             st_wr_en, st_rd_en;
   logic [SA_W-1:0]  st_addr;
   logic [127:0]     st_rd_data, row_data;
   logic [4:0]       n_words, idx0, remain;
   logic [31:0]      tw [4];

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign q_pop = (state_ff == S_IDLE) && !q_empty;
   assign q_blk = q_cmd.location[BLK_W-1:0];
   assign c_blk = cmd_ff.location[BLK_W-1:0];
   assign commit_done = commit_done_ff;

   assign st_addr    = base_ff + SA_W'(row_ff);
   assign st_rd_en   = state_ff == S_RD_ISSUE;
   assign st_wr_en   = state_ff == S_CP_WRITE;
   assign pb_rd_en   = state_ff == S_CP_READ;
   assign pb_rd_addr = row_ff;

   mcbs_ram #(.WIDTH(128), .DEPTH(ST_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_addr),
      .wr_data (pb_rd_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_addr),
      .rd_data (st_rd_data)
   );

   // a block never committed reads as erased
   assign row_data = blk_written_ff ? st_rd_data : {128{1'b1}};

   always_comb begin
      n_words = (cmd_ff.kind == CMD_DEVINFO) ? DEVINFO_WORDS : MEDIA_WORDS;
      idx0 = {k_ff, 2'b00};
      remain = n_words - idx0;
      for (int j = 0; j < 4; j++) begin
         logic [4:0] ix;
         ix = idx0 + 5'(j);
         if (ix >= n_words) tw[j] = 32'h0;
         else if (ix == 5'd0) tw[j] = function_code;
         else if (cmd_ff.kind == CMD_DEVINFO) tw[j] = dev_word(ix);
         else tw[j] = media_word(ix[2:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         commit_done_ff <= 1'b0;
         for (int b = 0; b < BLOCK_COUNT; b++) written_ff[b] <= 1'b0;
      end else begin
         commit_done_ff <= 1'b0;
         if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  cmd_ff <= q_cmd;
                  base_ff <= SA_W'(32'(q_blk) * ROWS);
                  blk_written_ff <= written_ff[q_blk];
                  row_ff <= '0;
                  k_ff <= 3'd0;
                  unique case (q_cmd.kind)
                     CMD_DEVINFO, CMD_MEDIA: state_ff <= S_TABLE;
                     CMD_READ:   state_ff <= S_RD_ISSUE;
                     CMD_COMMIT: state_ff <= S_CP_READ;
                     default:    state_ff <= S_PLAIN;
                  endcase
               end
            end
            S_PLAIN: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_code_ff <= cmd_ff.rsp;
                  rsp_err_ff <= cmd_ff.err;
                  w0_ff <= cmd_ff.word;
                  {w1_ff, w2_ff, w3_ff} <= '0;
                  vw_ff <= (cmd_ff.rsp == RSP_FILEERR) ? 3'd1 : 3'd0;
                  last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_TABLE: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_code_ff <= cmd_ff.rsp;
                  rsp_err_ff <= ERR_NONE;
                  {w3_ff, w2_ff, w1_ff, w0_ff} <= {tw[3], tw[2], tw[1], tw[0]};
                  vw_ff <= (remain >= 5'd4) ? 3'd4 : remain[2:0];
                  last_ff <= remain <= 5'd4;
                  k_ff <= k_ff + 3'd1;
                  if (remain <= 5'd4) state_ff <= S_IDLE;
               end
            end
            S_RD_ISSUE: state_ff <= S_RD_LOAD;
            S_RD_LOAD: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_code_ff <= RSP_DATA;
                  rsp_err_ff <= ERR_NONE;
                  if (row_ff == '0) begin
                     w0_ff <= function_code;
                     w1_ff <= cmd_ff.location;
                  end else begin
                     w0_ff <= prev_hi_ff[63:32];
                     w1_ff <= prev_hi_ff[95:64];
                  end
                  w2_ff <= row_data[31:0];
                  w3_ff <= row_data[63:32];
                  prev_hi_ff <= {row_data[127:64], 32'h0};
                  vw_ff <= 3'd4;
                  last_ff <= 1'b0;
                  if (row_ff == PB_AW'(ROWS - 1)) state_ff <= S_RD_TAIL;
                  else begin
                     row_ff <= row_ff + 1'b1;
                     state_ff <= S_RD_ISSUE;
                  end
               end
            end
            S_RD_TAIL: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_code_ff <= RSP_DATA;
                  rsp_err_ff <= ERR_NONE;
                  w0_ff <= prev_hi_ff[63:32];
                  w1_ff <= prev_hi_ff[95:64];
                  {w2_ff, w3_ff} <= '0;
                  vw_ff <= 3'd2;
                  last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_CP_READ: state_ff <= S_CP_WRITE;
            S_CP_WRITE: begin
               if (row_ff == PB_AW'(ROWS - 1)) begin
                  written_ff[c_blk] <= 1'b1;
                  commit_done_ff <= 1'b1;
                  state_ff <= S_PLAIN;
               end else begin
                  row_ff <= row_ff + 1'b1;
                  state_ff <= S_CP_READ;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.response    = rsp_code_ff;
   assign rsp.error       = rsp_err_ff;
   assign rsp.word0       = w0_ff;
   assign rsp.word1       = w1_ff;
   assign rsp.word2       = w2_ff;
   assign rsp.word3       = w3_ff;
   assign rsp.valid_words = vw_ff;
   assign rsp.last_result = last_ff;

   a_err_only_on_fileerr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_code_ff != RSP_FILEERR) |-> rsp_err_ff == ERR_NONE)
      else $error("error code without file error");
   a_words_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> vw_ff <= 3'd4) else $error("valid word count out of range");
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_IDLE) else $error("command popped but not started");
endmodule

FILE: rtl/core/memory_card_block_store_top.sv
// Top level of the memory card block store: registers, queue and buffer wiring.
`timescale 1ns / 1ps
// Emulated memory-card block device. Requests come in as beats (header plus
// four data words, last marks the end of a request); the front end accepts a
// beat per cycle while its two-entry command queue has room and fills the
// phase buffer from write beats as they arrive. The back end streams reply
// beats through a registered output slot: plain replies take one beat, device
// info 7 beats and media info 2 beats at one per cycle while the receiver is
// ready, a block read 33 beats with one store RAM read per row. A sync commit
// copies the phase buffer into block storage row by row, a phase buffer read
// then a store write per 16-byte row; no request beat is accepted during that
// copy. Storage needs no clearing pass after reset: a per-block written flag
// makes blocks that were never committed read as all ones. Configuration
// registers must be written only while the block is idle.
module memory_card_block_store_top #(
   parameter int BLOCK_COUNT = 256,
   parameter int BLOCK_BYTES = 512,
   parameter int PHASE_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   mcbs_req_if.sink    req_bus,
   mcbs_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import mcbs_pkg::*;

   localparam int ROWS = BLOCK_BYTES / 16;
   localparam int PB_AW = $clog2(ROWS);

   // configuration registers
   logic        wp_ff;
   logic [31:0] fc_ff;
   logic        wp_set;

   // phase buffer ports
   logic             pb_wr_en, pb_rd_en;
   logic [PB_AW-1:0] pb_wr_addr, pb_rd_addr;
   logic [127:0]     pb_wr_data, pb_rd_data;

   // queue handshake
   cmd_type push_cmd, pop_cmd;
   logic    q_push, q_pop, q_full, q_empty;
   logic    commit_done;

   // setting write protect also drops any pending write
   assign wp_set = csr_we && (csr_index == CSR_WRITE_PROTECT) && csr_wdata[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         fc_ff <= FUNCTION_CODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WRITE_PROTECT: wp_ff <= csr_wdata[0];
            CSR_FUNCTION_CODE: fc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mcbs_front #(
      .BLOCK_COUNT (BLOCK_COUNT),
      .BLOCK_BYTES (BLOCK_BYTES),
      .PHASE_BYTES (PHASE_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .write_protect (wp_ff),
      .function_code (fc_ff),
      .wp_set        (wp_set),
      .commit_done   (commit_done),
      .pb_wr_en      (pb_wr_en),
      .pb_wr_addr    (pb_wr_addr),
      .pb_wr_data    (pb_wr_data),
      .q_push        (q_push),
      .q_cmd         (push_cmd),
      .q_full        (q_full)
   );

   // 16-byte rows: one write beat fills one row
   mcbs_ram #(.WIDTH(128), .DEPTH(ROWS)) u_phase_buf (
      .clock   (clock),
      .wr_en   (pb_wr_en),
      .wr_addr (pb_wr_addr),
      .wr_data (pb_wr_data),
      .rd_en   (pb_rd_en),
      .rd_addr (pb_rd_addr),
      .rd_data (pb_rd_data)
   );

   mcbs_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   mcbs_back #(
      .BLOCK_COUNT (BLOCK_COUNT),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .function_code (fc_ff),
      .q_empty       (q_empty),
      .q_cmd         (pop_cmd),
      .q_pop         (q_pop),
      .pb_rd_en      (pb_rd_en),
      .pb_rd_addr    (pb_rd_addr),
      .pb_rd_data    (pb_rd_data),
      .commit_done   (commit_done),
      .rsp           (rsp_bus)
   );
endmodule

FILE: verif/memory_card_block_store_top_test.sv
// Self-checking testbench for the memory card block store top level.
`timescale 1ns / 1ps
module memory_card_block_store_top_test;
   import mcbs_pkg::*;

   // Default geometry: 256 blocks of 128 words, four 32-word phases,
   // eight beats per phase.
   localparam int NUM_BLOCKS   = 256;
   localparam int WORDS_PER_BLK = 128;
   localparam int WORDS_PER_PH = 32;
   localparam int BEATS_PER_PH = 8;
   localparam int NUM_PHASES   = 4;
   localparam logic [2:0] FUNC_OTHER = 3'd5;

   typedef struct {
      logic [2:0]  func;
      logic [7:0]  plen;
      logic [31:0] fword;
      logic [31:0] loc;
      logic [31:0] d [4];
      logic        last;
   } req_beat_type;

   typedef struct {
      logic [2:0]  rsp;
      logic [2:0]  err;
      logic [31:0] w [4];
      logic [2:0]  cnt;
      logic        last;
   } rsp_beat_type;

   // Predicts reply beats from accepted request beats and checks the DUT output.
   class card_scoreboard;
      logic [31:0] card [NUM_BLOCKS*WORDS_PER_BLK];
      logic [31:0] ph_buf [WORDS_PER_BLK];
      logic [31:0] reply_words [WORDS_PER_BLK+2];
      bit          pend_valid;
      int unsigned pend_block;
      int unsigned pend_next;
      bit          wr_protect;
      logic [31:0] func_code;
      bit          in_req;
      int unsigned beat_count;
      logic [2:0]  h_func;
      logic [7:0]  h_len;
      logic [31:0] h_fword;
      logic [31:0] h_loc;
      rsp_beat_type expected_beats [$];
      int          errors;

      function new();
         foreach (card[i]) card[i] = '1;
         foreach (ph_buf[i]) ph_buf[i] = '0;
         pend_valid = 0;
         pend_block = 0;
         pend_next  = 0;
         wr_protect = 0;
         func_code  = FUNCTION_CODE_RESET;
         in_req     = 0;
         beat_count = 0;
         errors     = 0;
      endfunction

      function void set_reg(logic idx, logic [31:0] val);
         if (idx == CSR_WRITE_PROTECT) begin
            wr_protect = val[0];
            if (wr_protect) pend_valid = 0;
         end else begin
            func_code = val;
         end
      endfunction

      // split n reply words into beats of four
      function void emit(logic [2:0] rsp, logic [2:0] err, int n);
         int nres;
         rsp_beat_type r;
         nres = (n == 0) ? 1 : (n + 3) / 4;
         for (int k = 0; k < nres; k++) begin
            r.rsp = rsp;
            r.err = err;
            r.cnt = 0;
            for (int j = 0; j < 4; j++) begin
               r.w[j] = (k*4 + j < n) ? reply_words[k*4 + j] : '0;
               if (k*4 + j < n) r.cnt++;
            end
            r.last = (k + 1 == nres);
            expected_beats.insert(expected_beats.size(), r);
         end
      endfunction

      function void file_err(logic [2:0] code, bit drop);
         if (drop) pend_valid = 0;
         reply_words[0] = FILE_ERROR_BASE << code;
         emit(RSP_FILEERR, code, 1);
      endfunction

      function void device_info();
         byte unsigned b [112];
         byte unsigned dname [13] = '{8'h56, 8'h69, 8'h73, 8'h75, 8'h61, 8'h6C, 8'h20,
                                      8'h4D, 8'h65, 8'h6D, 8'h6F, 8'h72, 8'h79};
         byte unsigned maker [55] = '{
            8'h50, 8'h72, 8'h6F, 8'h64, 8'h75, 8'h63, 8'h65, 8'h64, 8'h20, 8'h42, 8'h79,
            8'h20, 8'h6F, 8'h72, 8'h20, 8'h55, 8'h6E, 8'h64, 8'h65, 8'h72, 8'h20, 8'h4C,
            8'h69, 8'h63, 8'h65, 8'h6E, 8'h73, 8'h65, 8'h20, 8'h46, 8'h72, 8'h6F, 8'h6D,
            8'h20, 8'h53, 8'h45, 8'h47, 8'h41, 8'h20, 8'h45, 8'h4E, 8'h54, 8'h45, 8'h52,
            8'h50, 8'h52, 8'h49, 8'h53, 8'h45, 8'h53, 8'h2C, 8'h4C, 8'h54, 8'h44, 8'h2E};
         logic [31:0] id_word;
         id_word = 32'h0041_0F00;
         foreach (b[i]) b[i] = 8'h20;
         for (int i = 0; i < 4; i++) begin
            b[i]      = func_code[8*i +: 8];
            b[4 + i]  = id_word[8*i +: 8];
            b[8 + i]  = 0;
            b[12 + i] = 0;
         end
         b[16] = 8'hFF;
         b[17] = 0;
         foreach (dname[i]) b[18 + i] = dname[i];
         foreach (maker[i]) b[48 + i] = maker[i];
         b[108] = 8'h7C; b[109] = 0; b[110] = 8'h82; b[111] = 0;
         for (int i = 0; i < 28; i++)
            reply_words[i] = {b[4*i+3], b[4*i+2], b[4*i+1], b[4*i]};
         emit(RSP_DEVINFO, ERR_NONE, 28);
      endfunction

      function void respond();
         int unsigned blk, ph, part;
         logic [31:0] media [6] = '{32'h0000_00FF, 32'h00FE_00FF, 32'h00FD_0001,
                                    32'h0000_000D, 32'h001F_00C8, 32'h0080_0000};
         blk  = h_loc[15:0];
         ph   = h_loc[23:16];
         part = h_loc[31:24];
         if (h_func == FUNC_DEVINFO) begin
            device_info();
            return;
         end
         if (h_func > FUNC_SYNC) begin
            emit(RSP_UNKNOWN, ERR_NONE, 0);
            return;
         end
         if (h_len == 0 || h_fword != func_code) begin
            emit(RSP_NOFUNC, ERR_NONE, 0);
            return;
         end
         if (h_func == FUNC_MEDIA || h_func == FUNC_READ) begin
            if (h_len != 2) file_err(ERR_LENGTH, 0);
            else if (part != 0) file_err(ERR_PARTITION, 0);
            else if (ph != 0) file_err(ERR_PHASE, 0);
            else if (h_func == FUNC_MEDIA) begin
               if (blk != 0) file_err(ERR_BLOCK, 0);
               else begin
                  reply_words[0] = func_code;
                  for (int i = 0; i < 6; i++) reply_words[1 + i] = media[i];
                  emit(RSP_DATA, ERR_NONE, 7);
               end
            end else if (blk >= NUM_BLOCKS) file_err(ERR_BLOCK, 0);
            else begin
               reply_words[0] = func_code;
               reply_words[1] = h_loc;
               for (int i = 0; i < WORDS_PER_BLK; i++)
                  reply_words[2 + i] = card[blk*WORDS_PER_BLK + i];
               emit(RSP_DATA, ERR_NONE, WORDS_PER_BLK + 2);
            end
            return;
         end
         if (h_func == FUNC_WRITE) begin
            if (h_len != 2 + WORDS_PER_PH || beat_count != BEATS_PER_PH)
               file_err(ERR_LENGTH, 1);
            else if (part != 0) file_err(ERR_PARTITION, 1);
            else if (blk >= NUM_BLOCKS) file_err(ERR_BLOCK, 1);
            else if (ph >= NUM_PHASES) file_err(ERR_PHASE, 1);
            else if (wr_protect) file_err(ERR_WRFAIL, 1);
            else if (ph != 0 && (!pend_valid || pend_block != blk || pend_next != ph))
               file_err((pend_valid && pend_block != blk) ? ERR_BLOCK : ERR_PHASE, 1);
            else begin
               if (ph == 0) begin
                  pend_valid = 1;
                  pend_block = blk;
               end
               pend_next = ph + 1;
               emit(RSP_ACK, ERR_NONE, 0);
            end
            return;
         end
         // sync
         if (h_len != 2) file_err(ERR_LENGTH, 1);
         else if (part != 0) file_err(ERR_PARTITION, 1);
         else if (blk >= NUM_BLOCKS) file_err(ERR_BLOCK, 1);
         else if (ph != NUM_PHASES) file_err(ERR_PHASE, 1);
         else if (!pend_valid) file_err(ERR_PHASE, 0);
         else if (pend_block != blk) file_err(ERR_BLOCK, 1);
         else if (pend_next != NUM_PHASES) file_err(ERR_PHASE, 1);
         else if (wr_protect) file_err(ERR_WRFAIL, 1);
         else begin
            for (int i = 0; i < WORDS_PER_BLK; i++)
               card[pend_block*WORDS_PER_BLK + i] = ph_buf[i];
            pend_valid = 0;
            emit(RSP_ACK, ERR_NONE, 0);
         end
      endfunction

      function void note_beat(req_beat_type b);
         int unsigned ph;
         if (!in_req) begin
            in_req     = 1;
            beat_count = 0;
            h_func     = b.func;
            h_len      = b.plen;
            h_fword    = b.fword;
            h_loc      = b.loc;
         end
         if (h_func == FUNC_WRITE && h_len != 0 && h_fword == func_code
             && beat_count < BEATS_PER_PH) begin
            ph = h_loc[23:16];
            if (ph < NUM_PHASES)
               for (int j = 0; j < 4; j++)
                  ph_buf[ph*WORDS_PER_PH + beat_count*4 + j] = b.d[j];
         end
         if (beat_count < 32'hFFFF) beat_count++;
         if (b.last) begin
            in_req = 0;
            respond();
         end
      endfunction

      function void check(rsp_beat_type got);
         rsp_beat_type exp_b;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected reply beat rsp=%0d err=%0d", $time, got.rsp, got.err);
            errors++;
            return;
         end
         exp_b = expected_beats.pop_front();
         if (got.rsp !== exp_b.rsp || got.err !== exp_b.err || got.cnt !== exp_b.cnt
             || got.last !== exp_b.last || got.w[0] !== exp_b.w[0]
             || got.w[1] !== exp_b.w[1] || got.w[2] !== exp_b.w[2]
             || got.w[3] !== exp_b.w[3]) begin
            $display("%0t: mismatch expected rsp=%0d err=%0d w=%h %h %h %h cnt=%0d last=%0d",
                     $time, exp_b.rsp, exp_b.err, exp_b.w[0], exp_b.w[1], exp_b.w[2],
                     exp_b.w[3], exp_b.cnt, exp_b.last);
            $display("%0t:          actual   rsp=%0d err=%0d w=%h %h %h %h cnt=%0d last=%0d",
                     $time, got.rsp, got.err, got.w[0], got.w[1], got.w[2], got.w[3],
                     got.cnt, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic        csr_index = CSR_WRITE_PROTECT;
   logic [31:0] csr_wdata = '0;

   mcbs_req_if req_bus ();
   mcbs_rsp_if rsp_bus ();

   memory_card_block_store_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   card_scoreboard sb = new();
   bit          quiet = 0;      // no idling on either side in the final stretch
   int          beats_sent = 0;
   logic [31:0] cur_fcode = FUNCTION_CODE_RESET;

   initial begin
      req_bus.valid = 0;
      req_bus.func = '0;
      req_bus.payload_len = '0;
      req_bus.function_word = '0;
      req_bus.location = '0;
      req_bus.data0 = '0;
      req_bus.data1 = '0;
      req_bus.data2 = '0;
      req_bus.data3 = '0;
      req_bus.last = 0;
      rsp_bus.ready = 0;
   end

   // Response side: check every accepted beat, stall in random bursts.
   initial begin
      rsp_beat_type got;
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.rsp  = rsp_bus.response;
            got.err  = rsp_bus.error;
            got.w[0] = rsp_bus.word0;
            got.w[1] = rsp_bus.word1;
            got.w[2] = rsp_bus.word2;
            got.w[3] = rsp_bus.word3;
            got.cnt  = rsp_bus.valid_words;
            got.last = rsp_bus.last_result;
            sb.check(got);
         end
         if (stall > 0) stall--;
         else if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 15);
         rsp_bus.ready <= (stall == 0);
      end
   end

   // Random sender gap before a beat.
   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic send_beat(req_beat_type b);
      sender_gap();
      req_bus.valid         <= 1;
      req_bus.func          <= b.func;
      req_bus.payload_len   <= b.plen;
      req_bus.function_word <= b.fword;
      req_bus.location      <= b.loc;
      req_bus.data0         <= b.d[0];
      req_bus.data1         <= b.d[1];
      req_bus.data2         <= b.d[2];
      req_bus.data3         <= b.d[3];
      req_bus.last          <= b.last;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_beat(b);
      beats_sent++;
   endtask

   // One request of nbeats beats; later beats carry random (ignored) headers.
   task automatic send_request(logic [2:0] func, logic [7:0] plen, logic [31:0] fword,
                               logic [31:0] loc, int nbeats);
      req_beat_type b;
      for (int i = 0; i < nbeats; i++) begin
         b.func  = (i == 0) ? func : 3'($urandom);
         b.plen  = (i == 0) ? plen : 8'($urandom);
         b.fword = (i == 0) ? fword : $urandom;
         b.loc   = (i == 0) ? loc : $urandom;
         for (int j = 0; j < 4; j++) b.d[j] = $urandom;
         b.last = (i == nbeats - 1);
         send_beat(b);
      end
   endtask

   // Hold the sender off until every reply has drained, plus the commit copy time.
   task automatic drain();
      req_bus.valid <= 0;
      do @(posedge clock); while (sb.expected_beats.size() != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] val);
      drain();
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      if (idx == CSR_FUNCTION_CODE) cur_fcode = val;
      csr_we <= 0;
   endtask

   function automatic logic [31:0] loc_of(int part, int ph, int blk);
      return {8'(part), 8'(ph), 16'(blk)};
   endfunction

   // Four-phase write of one block and a sync; corrupt > 0 breaks at most one step.
   task automatic block_write_run(int blk, int corrupt);
      int bad_ph;
      int nb;
      int ph_field;
      bad_ph = $urandom_range(0, NUM_PHASES);
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         nb = BEATS_PER_PH;
         ph_field = ph;
         if (corrupt != 0 && ph == bad_ph) begin
            case (corrupt)
               1: nb = $urandom_range(0, 1) ? 7 : 9;
               2: ph_field = $urandom_range(0, 1) ? ph + 1 : 0;
               default: ;
            endcase
         end
         if (corrupt == 3 && ph == bad_ph && ph != 0)
            send_request(FUNC_WRITE, 8'(2 + WORDS_PER_PH), cur_fcode,
                         loc_of(0, ph, (blk + 1) % NUM_BLOCKS), nb);
         else if (!(corrupt == 4 && ph == bad_ph))
            send_request(FUNC_WRITE, 8'(2 + WORDS_PER_PH), cur_fcode,
                         loc_of(0, ph_field, blk), nb);
      end
      send_request(FUNC_SYNC, 8'd2, cur_fcode, loc_of(0, NUM_PHASES, blk), 1);
   endtask

   function automatic int pick_block();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return NUM_BLOCKS - 1;
         default: return $urandom_range(0, 7);
      endcase
   endfunction

   task automatic random_phase(int target);
      int blk;
      int sel;
      while (beats_sent < target) begin
         sel = $urandom_range(0, 11);
         blk = pick_block();
         case (sel)
            0, 1, 2, 3: begin
               block_write_run(blk,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
               send_request(FUNC_READ, 8'd2, cur_fcode, loc_of(0, 0, blk), 1);
            end
            4, 5: send_request(FUNC_READ, 8'd2, cur_fcode,
                               $urandom_range(0, 3) == 0 ? $urandom : loc_of(0, 0, blk),
                               $urandom_range(1, 2));
            6: send_request(3'($urandom_range(0, 1)), 8'd2, cur_fcode,
                            $urandom_range(0, 3) == 0 ? $urandom : 32'h0, 1);
            7, 8: send_request(3'($urandom), 8'($urandom), $urandom, $urandom,
                               $urandom_range(1, 3));
            9: send_request($urandom_range(0, 1) ? FUNC_WRITE : FUNC_SYNC,
                            $urandom_range(0, 1) ? 8'd0 : 8'(2 + WORDS_PER_PH),
                            $urandom_range(0, 1) ? cur_fcode : $urandom,
                            loc_of(0, $urandom_range(0, 4), blk), $urandom_range(1, 9));
            10: send_request(FUNC_SYNC, 8'($urandom_range(1, 3)), cur_fcode,
                             loc_of($urandom_range(0, 8) == 0, $urandom_range(3, 5),
                                    $urandom_range(0, 1) ? blk : $urandom_range(0, 300)),
                             1);
            default: send_request(FUNC_WRITE, 8'(2 + WORDS_PER_PH), cur_fcode,
                                  loc_of($urandom_range(0, 6) == 0, $urandom_range(0, 5),
                                         $urandom_range(0, 6) == 0 ? 16'hFFFF : blk),
                                  BEATS_PER_PH);
         endcase
      end
   endtask

   // Timeout watchdog.
   initial begin
      #4000000;
      $display("memory_card_block_store_top_test failed");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: info replies, read bounds, unknown funcs, header errors.
      send_request(FUNC_DEVINFO, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      send_request(FUNC_MEDIA, 8'd2, cur_fcode, 32'h0, 1);
      send_request(FUNC_MEDIA, 8'd2, cur_fcode, loc_of(0, 0, 1), 1);
      send_request(FUNC_READ, 8'd2, cur_fcode, loc_of(0, 0, 0), 1);
      send_request(FUNC_READ, 8'd2, cur_fcode, 32'hFFFF_FFFF, 1);
      send_request(FUNC_READ, 8'd2, cur_fcode, loc_of(1, 0, 0), 1);
      send_request(FUNC_READ, 8'd2, cur_fcode, loc_of(0, 1, 0), 1);
      send_request(FUNC_READ, 8'd2, cur_fcode, loc_of(0, 0, NUM_BLOCKS), 1);
      send_request(FUNC_READ, 8'd3, cur_fcode, 32'h0, 1);
      send_request(FUNC_OTHER, 8'd2, cur_fcode, 32'h0, 1);
      send_request(3'd7, 8'd2, cur_fcode, 32'h0, 1);
      send_request(FUNC_READ, 8'd0, cur_fcode, 32'h0, 1);
      send_request(FUNC_READ, 8'd2, ~cur_fcode, 32'h0, 1);
      // sync with nothing pending, bad sync length, short write, full phase-0 write
      send_request(FUNC_SYNC, 8'd2, cur_fcode, loc_of(0, NUM_PHASES, 0), 1);
      send_request(FUNC_SYNC, 8'd5, cur_fcode, loc_of(0, NUM_PHASES, 0), 1);
      send_request(FUNC_WRITE, 8'(2 + WORDS_PER_PH), cur_fcode, loc_of(0, 0, 0), 1);
      send_request(FUNC_WRITE, 8'(2 + WORDS_PER_PH), cur_fcode, loc_of(0, 0, 255), 8);

      // Random phases under several register settings.
      random_phase(130);
      write_reg(CSR_FUNCTION_CODE, 32'hFFFF_FFFF);
      random_phase(230);
      drain();                      // sender waits until every reply is in
      write_reg(CSR_WRITE_PROTECT, 1'b1);
      write_reg(CSR_FUNCTION_CODE, 32'h0);
      random_phase(300);
      write_reg(CSR_WRITE_PROTECT, 1'b0);
      write_reg(CSR_FUNCTION_CODE, $urandom);
      random_phase(400);
      quiet = 1;
      random_phase(470);

      drain();
      if (sb.errors == 0) $display("memory_card_block_store_top_test passed");
      else $display("memory_card_block_store_top_test failed");
      $finish;
   end
endmodule
